[rtl/core/ktc_pkg.sv]
// types and constants for the keyword token counter
// no dependencies
package ktc_pkg;

  typedef struct packed {
    logic [7:0] text_char;
    logic       end_of_text;
  } ktc_in_t;

  typedef struct packed {
    logic        result_kind;
    logic [3:0]  keyword_index;
    logic [15:0] hit_count;
    logic        last_result;
  } ktc_out_t;

  localparam logic KIND_HIT  = 1'b0;
  localparam logic KIND_DUMP = 1'b1;

  localparam int NUM_KW  = 14;
  localparam int KW_BYTES = 16;

  // keywords, first byte in bits [7:0], zero padded
  function automatic logic [8*KW_BYTES-1:0] kw_text(input logic [3:0] k);
    logic [8*KW_BYTES-1:0] t;
    t = '0;
    case (k)
      4'd0:  t[8*7-1:0]  = {"enifed#"};
      4'd1:  t[8*5-1:0]  = {"rahc_"};
      4'd2:  t[8*4-1:0]  = {"otua"};
      4'd3:  t[8*5-1:0]  = {"kaerb"};
      4'd4:  t[8*4-1:0]  = {"esac"};
      4'd5:  t[8*4-1:0]  = {"rahc"};
      4'd6:  t[8*5-1:0]  = {"tsnoc"};
      4'd7:  t[8*8-1:0]  = {"eunitnoc"};
      4'd8:  t[8*7-1:0]  = {"tluafed"};
      4'd9:  t[8*15-1:0] = {"namuh si rre ot"};
      4'd10: t[8*8-1:0]  = {"dengisnu"};
      4'd11: t[8*4-1:0]  = {"diov"};
      4'd12: t[8*8-1:0]  = {"elitalov"};
      4'd13: t[8*5-1:0]  = {"elihw"};
      default: t = '0;
    endcase
    return t;
  endfunction

  function automatic logic [4:0] kw_len(input logic [3:0] k);
    logic [4:0] l;
    case (k)
      4'd0, 4'd8: l = 5'd7;
      4'd1, 4'd3, 4'd6, 4'd13: l = 5'd5;
      4'd2, 4'd4, 4'd5, 4'd11: l = 5'd4;
      4'd7, 4'd10, 4'd12: l = 5'd8;
      4'd9: l = 5'd15;
      default: l = 5'd0;
    endcase
    return l;
  endfunction

endpackage

[rtl/core/keyword_token_counter.sv]
// keyword token counter top level
// depends on ktc_pkg
//
// Takes one text character per item. A character that finishes no word leaves
// it ready for the next character; a finished word walks the keyword table one
// entry per cycle and, if it matches a keyword, then does a read-modify-write
// of its count in the count memory before the hit item is offered. End of text
// walks the count memory, reading each count and then offering it, giving 14
// dump items. The word buffer is a 16-byte register file; the counts live in
// a 14-entry memory with a registered read, cleared entry by entry after reset,
// during which no item is accepted. Results sit in an output register so the
// next item is taken while a result waits.
module keyword_token_counter (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  ktc_pkg::ktc_in_t   in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output ktc_pkg::ktc_out_t  out_data
);
  import ktc_pkg::*;

  localparam logic [2:0] M_IDLE = 3'd0, M_IDENT = 3'd1, M_STRING = 3'd2,
                         M_SLASH = 3'd3, M_COMMENT = 3'd4, M_CSTAR = 3'd5;

  localparam logic [2:0] S_CLEAR = 3'd0, S_RUN = 3'd1, S_MATCH = 3'd2,
                         S_RD = 3'd3, S_WR = 3'd4, S_DUMP = 3'd5, S_DRD = 3'd6;

  logic [2:0]  st_r;
  logic [2:0]  mode_r;
  logic [6:0]  wlen_r;
  logic [7:0]  wbuf_r [KW_BYTES];
  logic [3:0]  kidx_r;
  logic [3:0]  hit_r;
  logic        found_r;
  logic        dump_after_r;
  logic [3:0]  cidx_r;
  logic [15:0] cmem [NUM_KW];
  logic [15:0] crd_r;
  logic        obusy_r;
  ktc_out_t    obuf_r;

  wire ofree = !obusy_r || out_ready;
  wire load_out = ((st_r == S_WR) || (st_r == S_DRD)) && ofree;
  assign out_valid = obusy_r;
  assign out_data  = obuf_r;
  assign in_ready  = (st_r == S_RUN);

  wire       acc = in_valid && in_ready;
  wire [7:0] c   = in_data.text_char;
  wire alpha = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  wire digit = (c >= "0" && c <= "9");
  wire space = (c == " ") || (c >= 8'd9 && c <= 8'd13);

  // lexer step for one character
  logic [2:0] mode_nxt;
  logic       store, restart, finish;
  always_comb begin
    mode_nxt = mode_r;
    store = 1'b0; restart = 1'b0; finish = 1'b0;
    case (mode_r)
      M_IDENT: begin
        if (alpha || digit) begin
          store = 1'b1;
          if (wlen_r == 7'd98) finish = 1'b1;
        end else begin
          finish = 1'b1;
        end
      end
      M_STRING: begin
        if (c == "\"") finish = 1'b1;
        else begin
          store = 1'b1;
          if (wlen_r == 7'd98) finish = 1'b1;
        end
      end
      M_SLASH:   if (c == "*") mode_nxt = M_COMMENT; else mode_nxt = M_IDLE;
      M_COMMENT: if (c == "*") mode_nxt = M_CSTAR;
      M_CSTAR: begin
        if (c == "/") mode_nxt = M_IDLE;
        else if (c != "*") mode_nxt = M_COMMENT;
      end
      default: mode_nxt = M_IDLE;
    endcase
    if (finish) mode_nxt = M_IDLE;
    // idle handling of the character (also after an ident ends or lone slash)
    if ((mode_r == M_IDLE) || (mode_r > M_CSTAR) ||
        (mode_r == M_IDENT && !(alpha || digit)) ||
        (mode_r == M_SLASH && c != "*")) begin
      if (space) mode_nxt = M_IDLE;
      else if (alpha || c == "_" || c == "#") begin
        mode_nxt = M_IDENT; restart = 1'b1;
      end else if (c == "\"") mode_nxt = M_STRING;
      else if (c == "/") mode_nxt = M_SLASH;
      else mode_nxt = M_IDLE;
    end
  end

  // table compare against current entry
  logic [8*KW_BYTES-1:0] kt;
  logic kmatch;
  always_comb begin
    kt = kw_text(kidx_r);
    kmatch = ({2'b00, kw_len(kidx_r)} == wlen_r) && (kw_len(kidx_r) != 5'd0);
    for (int i = 0; i < KW_BYTES; i++)
      if (5'(i) < kw_len(kidx_r) && wbuf_r[i] != kt[8*i +: 8]) kmatch = 1'b0;
  end

  // pending restart char after a finished identifier
  logic       rs_pend_r;
  logic [7:0] rs_char_r;

  wire [15:0] cinc = (crd_r == 16'hFFFF) ? crd_r : crd_r + 16'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_CLEAR; mode_r <= M_IDLE; wlen_r <= '0; kidx_r <= '0;
      cidx_r <= '0; obusy_r <= 1'b0; found_r <= 1'b0; dump_after_r <= 1'b0;
      rs_pend_r <= 1'b0;
    end else begin
      if (load_out) obusy_r <= 1'b1;
      else if (out_ready) obusy_r <= 1'b0;
      case (st_r)
        S_CLEAR: begin
          cmem[cidx_r] <= '0;
          if (cidx_r == 4'(NUM_KW - 1)) begin
            cidx_r <= '0; st_r <= S_RUN;
          end else begin
            cidx_r <= cidx_r + 4'd1;
          end
        end
        S_RUN: if (acc) begin
          if (in_data.end_of_text) begin
            mode_r <= M_IDLE; rs_pend_r <= 1'b0;
            if (mode_r == M_IDENT || mode_r == M_STRING) begin
              dump_after_r <= 1'b1; kidx_r <= '0; found_r <= 1'b0; st_r <= S_MATCH;
            end else begin
              wlen_r <= '0; cidx_r <= '0; st_r <= S_DUMP;
            end
          end else begin
            mode_r <= mode_nxt;
            if (store) begin
              if (wlen_r < 7'(KW_BYTES)) wbuf_r[wlen_r[3:0]] <= c;
              wlen_r <= wlen_r + 7'd1;
            end
            if (finish) begin
              dump_after_r <= 1'b0; kidx_r <= '0; found_r <= 1'b0; st_r <= S_MATCH;
              rs_pend_r <= restart; rs_char_r <= c;
            end else if (restart) begin
              wbuf_r[0] <= c; wlen_r <= 7'd1;
            end
          end
        end
        S_MATCH: begin
          if (kmatch && !found_r) begin
            found_r <= 1'b1; hit_r <= kidx_r;
          end
          kidx_r <= kidx_r + 4'd1;
          if (kidx_r == 4'(NUM_KW - 1)) begin
            if ((kmatch || found_r) && wlen_r <= 7'(KW_BYTES)) st_r <= S_RD;
            else begin
              wlen_r <= rs_pend_r ? 7'd1 : 7'd0;
              if (rs_pend_r) wbuf_r[0] <= rs_char_r;
              rs_pend_r <= 1'b0;
              cidx_r <= '0;
              st_r <= dump_after_r ? S_DUMP : S_RUN;
            end
          end
        end
        S_RD: begin
          crd_r <= cmem[hit_r];
          st_r <= S_WR;
        end
        S_WR: if (ofree) begin
          cmem[hit_r] <= cinc;
          obuf_r <= '{KIND_HIT, hit_r, cinc, !dump_after_r};
          wlen_r <= rs_pend_r ? 7'd1 : 7'd0;
          if (rs_pend_r) wbuf_r[0] <= rs_char_r;
          rs_pend_r <= 1'b0;
          cidx_r <= '0;
          st_r <= dump_after_r ? S_DUMP : S_RUN;
        end
        S_DUMP: begin
          crd_r <= cmem[cidx_r];
          st_r <= S_DRD;
        end
        S_DRD: if (ofree) begin
          obuf_r <= '{KIND_DUMP, cidx_r, crd_r, cidx_r == 4'(NUM_KW - 1)};
          cidx_r <= cidx_r + 4'd1;
          if (cidx_r == 4'(NUM_KW - 1)) begin st_r <= S_RUN; wlen_r <= '0; end
          else st_r <= S_DUMP;
        end
        default: st_r <= S_CLEAR;
      endcase
    end
  end

  a_ready_run: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> st_r == S_RUN) else $error("ready outside run");
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> $stable(out_data)) else $error("output overwritten");
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.keyword_index < 4'(NUM_KW)) else $error("bad index");
  a_dump_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.result_kind == KIND_DUMP && out_data.last_result)
    |-> out_data.keyword_index == 4'(NUM_KW - 1)) else $error("dump last wrong");

endmodule

[tb/sv/keyword_token_counter_chk.sv]
// checker for the keyword token counter: tracks the lexer on accepted items,
// predicts hit and dump results and compares them with the result channel
// depends on ktc_pkg
module keyword_token_counter_chk (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  ktc_pkg::ktc_in_t  in_data,
  input  logic              out_valid,
  input  logic              out_ready,
  input  ktc_pkg::ktc_out_t out_data,
  output int                errors,
  output int                pending,
  output int                hits_seen,
  output int                dumps_seen
);
  import ktc_pkg::*;

  typedef enum logic [2:0] {
    LX_IDLE, LX_IDENT, LX_STRING, LX_SLASH, LX_COMMENT, LX_CSTAR
  } lex_mode_t;

  localparam int MAX_WORD  = 100;
  localparam int CNT_MAX   = 65535;

  string keywords [NUM_KW] = '{"#define", "_char", "auto", "break", "case", "char",
    "const", "continue", "default", "to err is human", "unsigned", "void",
    "volatile", "while"};

  lex_mode_t   mode;
  logic [7:0]  word_buf [KW_BYTES];
  int          word_len;
  logic [15:0] kw_count [NUM_KW];
  ktc_out_t    expected_q [$];
  ktc_out_t    item_res [$];

  function automatic bit is_letter(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic bit is_num(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit is_blank(logic [7:0] c);
    return c == " " || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic void add_result(logic kind, int k, logic [15:0] cnt);
    ktc_out_t r;
    r.result_kind   = kind;
    r.keyword_index = 4'(k);
    r.hit_count     = cnt;
    r.last_result   = 1'b0;
    item_res.push_back(r);
  endfunction

  function automatic void take_char(logic [7:0] c);
    if (word_len < KW_BYTES) word_buf[word_len] = c;
    word_len++;
  endfunction

  function automatic void close_word();
    bit same;
    if (word_len <= KW_BYTES) begin
      for (int k = 0; k < NUM_KW; k++) begin
        if (keywords[k].len() == word_len) begin
          same = 1;
          for (int i = 0; i < word_len; i++)
            if (word_buf[i] != keywords[k][i]) same = 0;
          if (same) begin
            if (kw_count[k] != CNT_MAX) kw_count[k]++;
            add_result(KIND_HIT, k, kw_count[k]);
            break;
          end
        end
      end
    end
    mode = LX_IDLE;
    word_len = 0;
  endfunction

  function automatic void start_char(logic [7:0] c);
    if (is_blank(c)) return;
    if (is_letter(c) || c == "_" || c == "#") begin
      word_len = 0;
      take_char(c);
      mode = LX_IDENT;
    end else if (c == "\"") begin
      word_len = 0;
      mode = LX_STRING;
    end else if (c == "/") begin
      mode = LX_SLASH;
    end
  endfunction

  function automatic void predict_item(ktc_in_t it);
    logic [7:0] c;
    c = it.text_char;
    item_res.delete();
    if (it.end_of_text) begin
      if (mode == LX_IDENT || mode == LX_STRING) close_word();
      mode = LX_IDLE;
      word_len = 0;
      for (int k = 0; k < NUM_KW; k++) add_result(KIND_DUMP, k, kw_count[k]);
    end else begin
      case (mode)
        LX_IDENT: begin
          if (is_letter(c) || is_num(c)) begin
            take_char(c);
            if (word_len >= MAX_WORD - 1) close_word();
          end else begin
            close_word();
            start_char(c);
          end
        end
        LX_STRING: begin
          if (c == "\"") close_word();
          else begin
            take_char(c);
            if (word_len >= MAX_WORD - 1) close_word();
          end
        end
        LX_SLASH: begin
          if (c == "*") mode = LX_COMMENT;
          else begin
            mode = LX_IDLE;
            start_char(c);
          end
        end
        LX_COMMENT: if (c == "*") mode = LX_CSTAR;
        LX_CSTAR: begin
          if (c == "/") mode = LX_IDLE;
          else if (c != "*") mode = LX_COMMENT;
        end
        default: start_char(c);
      endcase
    end
    if (item_res.size() > 0) item_res[item_res.size()-1].last_result = 1'b1;
    foreach (item_res[i]) expected_q.push_back(item_res[i]);
  endfunction

  assign pending = expected_q.size();

  always @(posedge clk) begin
    ktc_out_t e;
    if (!rst_n) begin
      mode = LX_IDLE;
      word_len = 0;
      foreach (kw_count[k]) kw_count[k] = '0;
      expected_q.delete();
      errors <= 0;
      hits_seen <= 0;
      dumps_seen <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          $error("unexpected result item %p", out_data);
          errors <= errors + 1;
        end else begin
          e = expected_q.pop_front();
          if (out_data.result_kind !== e.result_kind) begin
            $error("result_kind: expected %0d, got %0d", e.result_kind, out_data.result_kind);
            errors <= errors + 1;
          end else if (out_data.keyword_index !== e.keyword_index) begin
            $error("keyword_index: expected %0d, got %0d",
                   e.keyword_index, out_data.keyword_index);
            errors <= errors + 1;
          end else if (out_data.hit_count !== e.hit_count) begin
            $error("hit_count: expected %0d, got %0d", e.hit_count, out_data.hit_count);
            errors <= errors + 1;
          end else if (out_data.last_result !== e.last_result) begin
            $error("last_result: expected %0d, got %0d", e.last_result, out_data.last_result);
            errors <= errors + 1;
          end
          if (e.result_kind == KIND_HIT) hits_seen <= hits_seen + 1;
          else dumps_seen <= dumps_seen + 1;
        end
      end
      if (in_valid && in_ready) predict_item(in_data);
    end
  end

endmodule

[tb/sv/keyword_token_counter_tb.sv]
// testbench top for the keyword token counter: clock, reset, text stimulus,
// receiver stalls and verdict; depends on ktc_pkg, keyword_token_counter and
// keyword_token_counter_chk
module keyword_token_counter_tb;
  import ktc_pkg::*;

  localparam int IDLE_LIMIT = 3000;
  localparam int HOLD_CYCLES = 400;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_ready;
  ktc_in_t  in_data;
  logic     out_valid;
  logic     out_ready;
  ktc_out_t out_data;

  int errors, pending, hits_seen, dumps_seen;
  int items_sent;
  int idle_cycles;
  bit steady;
  bit hold_req;
  bit hold_done;

  string kw_list [NUM_KW] = '{"#define", "_char", "auto", "break", "case", "char",
    "const", "continue", "default", "to err is human", "unsigned", "void",
    "volatile", "while"};

  keyword_token_counter u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  keyword_token_counter_chk u_chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .errors(errors), .pending(pending), .hits_seen(hits_seen), .dumps_seen(dumps_seen)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic int gap_len();
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // receiver: random stalls, one long hold-off on request
  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1;
      end else if (steady || $urandom_range(0, 9) < 7) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b0;
        repeat (gap_len()) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic send(logic [7:0] c, logic eot);
    in_data  <= '{text_char: c, end_of_text: eot};
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
    if (!steady && $urandom_range(0, 9) < 3) begin
      in_valid <= 1'b0;
      repeat (gap_len()) @(posedge clk);
    end
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send(s[i], 1'b0);
  endtask

  task automatic send_ident(int n);
    logic [7:0] c;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 2))
        0: c = 8'($urandom_range("a", "z"));
        1: c = 8'($urandom_range("A", "Z"));
        default: c = (i == 0) ? "_" : 8'($urandom_range("0", "9"));
      endcase
      send(c, 1'b0);
    end
  endtask

  initial begin
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_data  <= '0;
    items_sent = 0;
    idle_cycles = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed: table ends, strings, lone slash, star runs in a comment,
    // high bytes, end of text inside a word and inside a comment
    send_text("#define/char/**x***/\"\"\"to err is human\"");
    send(8'hff, 1'b0);
    send(8'h80, 1'b0);
    send_text("while");
    send(8'h00, 1'b1);
    send_text("/*a");
    send(8'h7f, 1'b1);

    // random part: mostly keywords in varied framing, some noise
    send_text(" volatile ");
    send_ident(101);
    while (items_sent < 180) begin
      if (items_sent > 120 && !hold_req) hold_req = 1;
      if ($urandom_range(0, 9) == 0) steady = !steady;
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5, 6: begin
          send_text(kw_list[$urandom_range(0, NUM_KW-1)]);
          send_text($urandom_range(0, 1) ? " " : ";");
        end
        7, 8: send_text({"\"", kw_list[$urandom_range(0, NUM_KW-1)], "\""});
        9, 10: begin
          send_ident($urandom_range(1, 18));
          send(" ", 1'b0);
        end
        11: send_text("/**x*/");
        12: send_text({"/", kw_list[$urandom_range(0, NUM_KW-1)], "\t"});
        13, 14, 15: send(8'($urandom_range(0, 255)), 1'b0);
        16: send(8'($urandom_range(0, 255)), 1'b1);
        17: send_text({kw_list[$urandom_range(0, NUM_KW-1)], "9 "});
        default: send_text({"\"", kw_list[$urandom_range(0, NUM_KW-1)]});
      endcase
    end
    send(8'($urandom_range(0, 255)), 1'b1);
    in_valid <= 1'b0;

    // let the checker take the last item before looking at what is pending
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    $display("sent %0d text items; checked %0d keyword hits and %0d count dump entries",
             items_sent, hits_seen, dumps_seen);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/core/ktc_pkg.sv
rtl/core/keyword_token_counter.sv
tb/sv/keyword_token_counter_chk.sv
tb/sv/keyword_token_counter_tb.sv
